>>> src/lah_pkg.sv
// package: types, register map, condition codes and compare helpers for the limit alarm
`default_nettype none
package lah_pkg;

	localparam int DATA_W = 64;
	localparam int ADDR_W = 6;
	localparam int SEV_W  = 10;

	typedef logic signed [DATA_W-1:0] val_t;
	typedef logic [1:0] sev_t;

	typedef enum logic [2:0] {
		COND_NONE = 3'd0,
		COND_HIHI = 3'd1,
		COND_HIGH = 3'd2,
		COND_LOW  = 3'd3,
		COND_LOLO = 3'd4,
		COND_UDF  = 3'd5
	} cond_t;

	typedef enum logic [2:0] {
		REG_HIHI = 3'd0,
		REG_LOLO = 3'd1,
		REG_HIGH = 3'd2,
		REG_LOW  = 3'd3,
		REG_HYST = 3'd4,
		REG_SEVR = 3'd5,
		REG_MDEL = 3'd6,
		REG_ADEL = 3'd7
	} reg_idx_t;

	typedef struct packed {
		val_t             hihi;
		val_t             lolo;
		val_t             high;
		val_t             low;
		val_t             hyst;
		logic [SEV_W-1:0] sevr;
		val_t             mdel;
		val_t             adel;
	} cfg_t;

	// exact v >= a - h, widened so it never wraps
	function automatic logic ge_minus(input val_t v, input val_t a, input val_t h);
		logic signed [DATA_W:0] thr;
		thr = $signed({a[DATA_W-1], a}) - $signed({h[DATA_W-1], h});
		return $signed({v[DATA_W-1], v}) >= thr;
	endfunction

	// exact v <= a + h
	function automatic logic le_plus(input val_t v, input val_t a, input val_t h);
		logic signed [DATA_W:0] thr;
		thr = $signed({a[DATA_W-1], a}) + $signed({h[DATA_W-1], h});
		return $signed({v[DATA_W-1], v}) <= thr;
	endfunction

	// deadband check: negative band always fires, else |last - v| > band
	function automatic logic band_hit(input val_t last, input val_t v, input val_t band);
		logic signed [DATA_W:0] d_vl;
		logic signed [DATA_W:0] d_lv;
		logic [DATA_W-1:0]      mag;
		d_vl = $signed({v[DATA_W-1], v}) - $signed({last[DATA_W-1], last});
		d_lv = $signed({last[DATA_W-1], last}) - $signed({v[DATA_W-1], v});
		mag  = d_vl[DATA_W] ? d_lv[DATA_W-1:0] : d_vl[DATA_W-1:0];
		return band[DATA_W-1] || (mag > $unsigned(band));
	endfunction

endpackage
`default_nettype wire

>>> src/lah_sample_if.sv
// interface: sample channel with valid/ready handshake
`default_nettype none
interface lah_sample_if;
	logic          valid;
	logic          ready;
	lah_pkg::val_t sample_value;
	logic          sample_defined;

	modport source (output valid, output sample_value, output sample_defined, input ready);
	modport sink (input valid, input sample_value, input sample_defined, output ready);
endinterface
`default_nettype wire

>>> src/lah_result_if.sv
// interface: alarm result channel with valid/ready handshake
`default_nettype none
interface lah_result_if;
	logic       valid;
	logic       ready;
	logic [2:0] alarm_condition;
	logic [1:0] alarm_severity;
	logic       value_event;
	logic       archive_event;
	logic       alarm_event;

	modport source (output valid, output alarm_condition, output alarm_severity,
		output value_event, output archive_event, output alarm_event, input ready);
	modport sink (input valid, input alarm_condition, input alarm_severity,
		input value_event, input archive_event, input alarm_event, output ready);
endinterface
`default_nettype wire

>>> src/lah_regs.sv
// module: apb configuration register file for the limit alarm
`default_nettype none
module lah_regs (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         psel,
	input  wire logic                         penable,
	input  wire logic                         pwrite,
	input  wire logic [lah_pkg::ADDR_W-1:0]   paddr,
	input  wire logic [lah_pkg::DATA_W-1:0]   pwdata,
	output logic      [lah_pkg::DATA_W-1:0]   prdata,
	output logic                              pready,
	output lah_pkg::cfg_t                     cfg
);

	lah_pkg::cfg_t     cfg_q;
	lah_pkg::reg_idx_t idx;
	logic              wr_en;

	assign idx    = lah_pkg::reg_idx_t'(paddr[lah_pkg::ADDR_W-1:3]);
	assign wr_en  = psel && penable && pwrite && pready;
	assign pready = 1'b1;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (wr_en) begin
			unique case (idx)
				lah_pkg::REG_HIHI: cfg_q.hihi <= pwdata;
				lah_pkg::REG_LOLO: cfg_q.lolo <= pwdata;
				lah_pkg::REG_HIGH: cfg_q.high <= pwdata;
				lah_pkg::REG_LOW:  cfg_q.low  <= pwdata;
				lah_pkg::REG_HYST: cfg_q.hyst <= pwdata;
				lah_pkg::REG_SEVR: cfg_q.sevr <= pwdata[lah_pkg::SEV_W-1:0];
				lah_pkg::REG_MDEL: cfg_q.mdel <= pwdata;
				lah_pkg::REG_ADEL: cfg_q.adel <= pwdata;
				default:           cfg_q      <= cfg_q;
			endcase
		end
	end

	always_comb begin
		unique case (idx)
			lah_pkg::REG_HIHI: prdata = cfg_q.hihi;
			lah_pkg::REG_LOLO: prdata = cfg_q.lolo;
			lah_pkg::REG_HIGH: prdata = cfg_q.high;
			lah_pkg::REG_LOW:  prdata = cfg_q.low;
			lah_pkg::REG_HYST: prdata = cfg_q.hyst;
			lah_pkg::REG_SEVR: prdata = {{(lah_pkg::DATA_W-lah_pkg::SEV_W){1'b0}}, cfg_q.sevr};
			lah_pkg::REG_MDEL: prdata = cfg_q.mdel;
			lah_pkg::REG_ADEL: prdata = cfg_q.adel;
			default:           prdata = '0;
		endcase
	end

endmodule
`default_nettype wire

>>> src/limit_alarm_with_hysteresis_unit.sv
// Four-level limit alarm with hysteresis and value/archive deadbands.
// Channels: sample (sink) carries a signed 64-bit reading and a defined flag;
// result (source) carries alarm condition, severity and three event flags.
// One result per sample, in order. Handshake: transaction on valid && ready.
// Configuration: APB port, 64-bit data, register i at byte address 8*i,
// written on psel && penable && pwrite (pready is tied high); the user must write
// it only while no transaction is in flight; the block itself does not enforce this.
// Path: an accepted sample passes the input register, then the result register.
// Throughput: one sample per cycle while result is not stalled; the held alarm
// level and the last posted and archived values feed back from one sample to the next.
// A stalled result holds in its output register while the input register
// keeps one more sample; sample.ready falls only when both are full.
// Reset (arst_n low): registers, held level, last values and previous
// alarm state clear to zero; both channels come up empty.
`default_nettype none
module limit_alarm_with_hysteresis_unit (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	lah_sample_if.sink                       sample,
	lah_result_if.source                     result,
	input  wire logic                        psel,
	input  wire logic                        penable,
	input  wire logic                        pwrite,
	input  wire logic [lah_pkg::ADDR_W-1:0]  paddr,
	input  wire logic [lah_pkg::DATA_W-1:0]  pwdata,
	output logic      [lah_pkg::DATA_W-1:0]  prdata,
	output logic                             pready
);

	lah_pkg::cfg_t cfg;

	lah_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// input register
	logic          valid_s1;
	lah_pkg::val_t value_s1;
	logic          defined_s1;

	// result register
	logic           valid_s2;
	lah_pkg::cond_t cond_s2;
	lah_pkg::sev_t  sev_s2;
	logic           vev_s2;
	logic           aev_s2;
	logic           alev_s2;

	// alarm state
	lah_pkg::val_t  held_q;
	lah_pkg::val_t  posted_q;
	lah_pkg::val_t  archived_q;
	lah_pkg::cond_t prev_cond_q;
	lah_pkg::sev_t  prev_sev_q;

	logic adv;
	logic take_in;

	assign adv          = valid_s1 && (!valid_s2 || result.ready);
	assign sample.ready = !valid_s1 || adv;
	assign take_in      = sample.valid && sample.ready;

	lah_pkg::sev_t  hhsv, llsv, hsv, lsv, udfs;
	lah_pkg::cond_t cond;
	lah_pkg::sev_t  asev;
	lah_pkg::val_t  alev;
	logic           vev, aev, alarm_ev;

	assign hhsv = cfg.sevr[1:0];
	assign llsv = cfg.sevr[3:2];
	assign hsv  = cfg.sevr[5:4];
	assign lsv  = cfg.sevr[7:6];
	assign udfs = cfg.sevr[9:8];

	always_comb begin
		cond = lah_pkg::COND_NONE;
		asev = '0;
		alev = value_s1;
		if (!defined_s1) begin
			if (udfs != '0) begin
				cond = lah_pkg::COND_UDF;
				asev = udfs;
			end
		end else if (hhsv != '0 && ($signed(value_s1) >= $signed(cfg.hihi) ||
				(held_q == cfg.hihi && lah_pkg::ge_minus(value_s1, cfg.hihi, cfg.hyst)))) begin
			cond = lah_pkg::COND_HIHI;
			asev = hhsv;
			alev = cfg.hihi;
		end else if (llsv != '0 && ($signed(value_s1) <= $signed(cfg.lolo) ||
				(held_q == cfg.lolo && lah_pkg::le_plus(value_s1, cfg.lolo, cfg.hyst)))) begin
			cond = lah_pkg::COND_LOLO;
			asev = llsv;
			alev = cfg.lolo;
		end else if (hsv != '0 && ($signed(value_s1) >= $signed(cfg.high) ||
				(held_q == cfg.high && lah_pkg::ge_minus(value_s1, cfg.high, cfg.hyst)))) begin
			cond = lah_pkg::COND_HIGH;
			asev = hsv;
			alev = cfg.high;
		end else if (lsv != '0 && ($signed(value_s1) <= $signed(cfg.low) ||
				(held_q == cfg.low && lah_pkg::le_plus(value_s1, cfg.low, cfg.hyst)))) begin
			cond = lah_pkg::COND_LOW;
			asev = lsv;
			alev = cfg.low;
		end
	end

	assign alarm_ev = (cond != prev_cond_q) || (asev != prev_sev_q);
	assign vev      = lah_pkg::band_hit(posted_q, value_s1, cfg.mdel);
	assign aev      = lah_pkg::band_hit(archived_q, value_s1, cfg.adel);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (take_in) begin
			valid_s1 <= 1'b1;
		end else if (adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take_in) begin
			value_s1   <= sample.sample_value;
			defined_s1 <= sample.sample_defined;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv) begin
			valid_s2 <= 1'b1;
		end else if (result.ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			cond_s2 <= cond;
			sev_s2  <= asev;
			vev_s2  <= vev;
			aev_s2  <= aev;
			alev_s2 <= alarm_ev;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_q      <= '0;
			posted_q    <= '0;
			archived_q  <= '0;
			prev_cond_q <= lah_pkg::COND_NONE;
			prev_sev_q  <= '0;
		end else if (adv) begin
			if (defined_s1) begin
				held_q <= (asev != '0) ? alev : value_s1;
			end
			if (vev) begin
				posted_q <= value_s1;
			end
			if (aev) begin
				archived_q <= value_s1;
			end
			prev_cond_q <= cond;
			prev_sev_q  <= asev;
		end
	end

	assign result.valid           = valid_s2;
	assign result.alarm_condition = cond_s2;
	assign result.alarm_severity  = sev_s2;
	assign result.value_event     = vev_s2;
	assign result.archive_event   = aev_s2;
	assign result.alarm_event     = alev_s2;

endmodule
`default_nettype wire

>>> tb/tb.sv
`timescale 1ns / 1ps
// testbench: directed and random checking of the limit alarm unit against its own alarm predictor
module tb;

	localparam int            CYCLE_LIMIT    = 200000;
	localparam int            RX_HOLD_CYCLES = 300;
	localparam int            RANDOM_PHASES  = 9;
	localparam int            PHASE_ITEMS    = 92;
	localparam int            DRAIN_LIMIT    = 2000;
	localparam int            PRINT_LIMIT    = 50;
	localparam lah_pkg::val_t VAL_MIN        = {1'b1, {63{1'b0}}};
	localparam lah_pkg::val_t VAL_MAX        = {1'b0, {63{1'b1}}};

	typedef struct {
		lah_pkg::val_t             hihi;
		lah_pkg::val_t             lolo;
		lah_pkg::val_t             high;
		lah_pkg::val_t             low;
		lah_pkg::val_t             hyst;
		logic [lah_pkg::SEV_W-1:0] sevr;
		lah_pkg::val_t             mdel;
		lah_pkg::val_t             adel;
	} alarm_cfg_t;

	typedef struct {
		lah_pkg::val_t value;
		logic          defined;
	} sample_t;

	typedef struct {
		lah_pkg::cond_t cond;
		lah_pkg::sev_t  sev;
		logic           value_ev;
		logic           archive_ev;
		logic           alarm_ev;
	} alarm_out_t;

	logic                       clk;
	logic                       arst_n;
	logic                       psel;
	logic                       penable;
	logic                       pwrite;
	logic [lah_pkg::ADDR_W-1:0] paddr;
	logic [lah_pkg::DATA_W-1:0] pwdata;
	logic [lah_pkg::DATA_W-1:0] prdata;
	logic                       pready;

	lah_sample_if sample_ch ();
	lah_result_if result_ch ();

	limit_alarm_with_hysteresis_unit dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.sample  (sample_ch),
		.result  (result_ch),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	alarm_cfg_t     cfg_shadow;
	lah_pkg::val_t  held_level;
	lah_pkg::val_t  last_posted;
	lah_pkg::val_t  last_archived;
	lah_pkg::cond_t prev_cond;
	lah_pkg::sev_t  prev_sev;
	sample_t        samples_pending[$];
	alarm_out_t     alarm_expected[$];
	sample_t        next_item;
	alarm_out_t     due;
	int             err_count = 0;
	int             cycle_count = 0;
	int             tx_gap_max;
	int             rx_stall_max;
	int             burst_left;
	int             gap_left;
	int             rx_run_left;
	logic           rx_on;
	logic           rx_hold;
	logic           pressure_go;

	always #5 clk = ~clk;

	task automatic report_mismatch(input string what, input longint unsigned want,
			input longint unsigned got);
		if (err_count < PRINT_LIMIT)
			$display("tb: %s mismatch at cycle %0d: expected %0d, got %0d",
				what, cycle_count, want, got);
		err_count++;
	endtask

	// exact v >= lim - margin
	function automatic logic stays_above(input lah_pkg::val_t v, input lah_pkg::val_t lim,
			input lah_pkg::val_t margin);
		logic signed [lah_pkg::DATA_W+1:0] vw;
		logic signed [lah_pkg::DATA_W+1:0] lw;
		logic signed [lah_pkg::DATA_W+1:0] mw;
		vw = (lah_pkg::DATA_W+2)'(v);
		lw = (lah_pkg::DATA_W+2)'(lim);
		mw = (lah_pkg::DATA_W+2)'(margin);
		return vw + mw >= lw;
	endfunction

	// exact v <= lim + margin
	function automatic logic stays_below(input lah_pkg::val_t v, input lah_pkg::val_t lim,
			input lah_pkg::val_t margin);
		logic signed [lah_pkg::DATA_W+1:0] vw;
		logic signed [lah_pkg::DATA_W+1:0] lw;
		logic signed [lah_pkg::DATA_W+1:0] mw;
		vw = (lah_pkg::DATA_W+2)'(v);
		lw = (lah_pkg::DATA_W+2)'(lim);
		mw = (lah_pkg::DATA_W+2)'(margin);
		return vw - mw <= lw;
	endfunction

	function automatic logic band_crossed(inout lah_pkg::val_t last, input lah_pkg::val_t v,
			input lah_pkg::val_t band);
		logic signed [lah_pkg::DATA_W+1:0] diff_w;
		logic signed [lah_pkg::DATA_W+1:0] band_w;
		diff_w = (lah_pkg::DATA_W+2)'(v) - (lah_pkg::DATA_W+2)'(last);
		if (diff_w < 0)
			diff_w = -diff_w;
		band_w = (lah_pkg::DATA_W+2)'(band);
		if (band < 0 || diff_w > band_w) begin
			last = v;
			return 1'b1;
		end
		return 1'b0;
	endfunction

	function automatic void predict_alarm(input lah_pkg::val_t v, input logic defined);
		lah_pkg::sev_t sv_hihi;
		lah_pkg::sev_t sv_lolo;
		lah_pkg::sev_t sv_high;
		lah_pkg::sev_t sv_low;
		lah_pkg::sev_t sv_udf;
		alarm_out_t    r;
		lah_pkg::val_t level;
		sv_hihi = cfg_shadow.sevr[1:0];
		sv_lolo = cfg_shadow.sevr[3:2];
		sv_high = cfg_shadow.sevr[5:4];
		sv_low  = cfg_shadow.sevr[7:6];
		sv_udf  = cfg_shadow.sevr[9:8];
		r.cond = lah_pkg::COND_NONE;
		r.sev  = '0;
		level  = v;
		if (!defined) begin
			if (sv_udf != 0) begin
				r.cond = lah_pkg::COND_UDF;
				r.sev  = sv_udf;
			end
		end else begin
			if (sv_hihi != 0 && (v >= cfg_shadow.hihi || (held_level == cfg_shadow.hihi &&
					stays_above(v, cfg_shadow.hihi, cfg_shadow.hyst)))) begin
				r.cond = lah_pkg::COND_HIHI;
				r.sev  = sv_hihi;
				level  = cfg_shadow.hihi;
			end else if (sv_lolo != 0 && (v <= cfg_shadow.lolo || (held_level == cfg_shadow.lolo &&
					stays_below(v, cfg_shadow.lolo, cfg_shadow.hyst)))) begin
				r.cond = lah_pkg::COND_LOLO;
				r.sev  = sv_lolo;
				level  = cfg_shadow.lolo;
			end else if (sv_high != 0 && (v >= cfg_shadow.high || (held_level == cfg_shadow.high &&
					stays_above(v, cfg_shadow.high, cfg_shadow.hyst)))) begin
				r.cond = lah_pkg::COND_HIGH;
				r.sev  = sv_high;
				level  = cfg_shadow.high;
			end else if (sv_low != 0 && (v <= cfg_shadow.low || (held_level == cfg_shadow.low &&
					stays_below(v, cfg_shadow.low, cfg_shadow.hyst)))) begin
				r.cond = lah_pkg::COND_LOW;
				r.sev  = sv_low;
				level  = cfg_shadow.low;
			end
			held_level = (r.sev != 0) ? level : v;
		end
		r.alarm_ev = (r.cond != prev_cond) || (r.sev != prev_sev);
		prev_cond  = r.cond;
		prev_sev   = r.sev;
		r.value_ev   = band_crossed(last_posted, v, cfg_shadow.mdel);
		r.archive_ev = band_crossed(last_archived, v, cfg_shadow.adel);
		alarm_expected.push_back(r);
	endfunction

	function automatic void push_sample(input lah_pkg::val_t v, input logic d);
		samples_pending.push_back('{v, d});
	endfunction

	function automatic lah_pkg::val_t pick_band();
		case ($urandom_range(0, 4))
			0: return -1;
			1: return 0;
			2: return lah_pkg::val_t'($urandom_range(1, 40));
			3: return VAL_MAX;
			default: return VAL_MIN;
		endcase
	endfunction

	task automatic wait_idle();
		do
			@(negedge clk);
		while (samples_pending.size() != 0 || sample_ch.valid || alarm_expected.size() != 0);
	endtask

	task automatic reg_write(input lah_pkg::reg_idx_t idx,
			input logic [lah_pkg::DATA_W-1:0] data);
		@(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 3'b000};
		pwdata  <= data;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
	endtask

	task automatic write_cfg(input alarm_cfg_t c);
		wait_idle();
		reg_write(lah_pkg::REG_HIHI, c.hihi);
		reg_write(lah_pkg::REG_LOLO, c.lolo);
		reg_write(lah_pkg::REG_HIGH, c.high);
		reg_write(lah_pkg::REG_LOW, c.low);
		reg_write(lah_pkg::REG_HYST, c.hyst);
		reg_write(lah_pkg::REG_SEVR, {{(lah_pkg::DATA_W-lah_pkg::SEV_W){1'b0}}, c.sevr});
		reg_write(lah_pkg::REG_MDEL, c.mdel);
		reg_write(lah_pkg::REG_ADEL, c.adel);
		cfg_shadow = c;
	endtask

	// sender: bursts of random length with random gaps
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sample_ch.valid          <= 1'b0;
			sample_ch.sample_value   <= '0;
			sample_ch.sample_defined <= 1'b0;
			burst_left = 0;
			gap_left   = 0;
		end else begin
			if (sample_ch.valid && sample_ch.ready)
				predict_alarm(sample_ch.sample_value, sample_ch.sample_defined);
			if (!sample_ch.valid || sample_ch.ready) begin
				if (gap_left > 0) begin
					gap_left--;
					sample_ch.valid <= 1'b0;
				end else if (samples_pending.size() != 0) begin
					next_item = samples_pending.pop_front();
					sample_ch.sample_value   <= next_item.value;
					sample_ch.sample_defined <= next_item.defined;
					sample_ch.valid          <= 1'b1;
					if (burst_left > 0) begin
						burst_left--;
					end else begin
						burst_left = $urandom_range(1, 24);
						gap_left   = (tx_gap_max > 0) ? $urandom_range(1, tx_gap_max) : 0;
					end
				end else begin
					sample_ch.valid <= 1'b0;
				end
			end
		end
	end

	// receiver: checks each transaction, stalls in runs
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_ch.ready <= 1'b0;
			rx_on       = 1'b1;
			rx_run_left = 0;
		end else begin
			if (result_ch.valid && result_ch.ready) begin
				if (alarm_expected.size() == 0) begin
					report_mismatch("unexpected result", 0, 1);
				end else begin
					due = alarm_expected.pop_front();
					if (result_ch.alarm_condition !== due.cond)
						report_mismatch("alarm_condition", 64'(due.cond),
							64'(result_ch.alarm_condition));
					if (result_ch.alarm_severity !== due.sev)
						report_mismatch("alarm_severity", 64'(due.sev),
							64'(result_ch.alarm_severity));
					if (result_ch.value_event !== due.value_ev)
						report_mismatch("value_event", 64'(due.value_ev),
							64'(result_ch.value_event));
					if (result_ch.archive_event !== due.archive_ev)
						report_mismatch("archive_event", 64'(due.archive_ev),
							64'(result_ch.archive_event));
					if (result_ch.alarm_event !== due.alarm_ev)
						report_mismatch("alarm_event", 64'(due.alarm_ev),
							64'(result_ch.alarm_event));
				end
			end
			if (rx_run_left > 0) begin
				rx_run_left--;
			end else if (rx_stall_max == 0) begin
				rx_on       = 1'b1;
				rx_run_left = 16;
			end else begin
				rx_on       = !rx_on;
				rx_run_left = rx_on ? $urandom_range(0, 30) : $urandom_range(0, rx_stall_max - 1);
			end
			result_ch.ready <= rx_on && !rx_hold;
		end
	end

	// long receiver hold-off so the unit backs up and stalls its input
	initial begin
		rx_hold = 1'b0;
		wait (pressure_go);
		@(posedge clk);
		rx_hold <= 1'b1;
		repeat (RX_HOLD_CYCLES) @(posedge clk);
		rx_hold <= 1'b0;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("tb: done, errors");
			$finish;
		end
	end

	initial begin
		alarm_cfg_t    c;
		lah_pkg::val_t walk;
		lah_pkg::val_t off;
		lah_pkg::val_t center;
		lah_pkg::val_t spread;
		int            pick;
		int            drain;
		clk      = 1'b0;
		arst_n   = 1'b0;
		psel     = 1'b0;
		penable  = 1'b0;
		pwrite   = 1'b0;
		paddr    = '0;
		pwdata   = '0;
		sample_ch.valid          = 1'b0;
		sample_ch.sample_value   = '0;
		sample_ch.sample_defined = 1'b0;
		result_ch.ready          = 1'b0;
		cfg_shadow    = '{0, 0, 0, 0, 0, 0, 0, 0};
		held_level    = '0;
		last_posted   = '0;
		last_archived = '0;
		prev_cond     = lah_pkg::COND_NONE;
		prev_sev      = '0;
		tx_gap_max    = 0;
		rx_stall_max  = 0;
		pressure_go   = 1'b0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		// every level taken, held by hysteresis and released
		c = '{hihi: 100, lolo: -100, high: 50, low: -50, hyst: 10, sevr: 10'h35A,
			mdel: 5, adel: -1};
		write_cfg(c);
		push_sample(0, 1'b1);
		push_sample(60, 1'b1);
		push_sample(45, 1'b1);
		push_sample(39, 1'b1);
		push_sample(150, 1'b1);
		push_sample(95, 1'b1);
		push_sample(89, 1'b1);
		push_sample(-60, 1'b1);
		push_sample(-45, 1'b1);
		push_sample(-39, 1'b1);
		push_sample(-200, 1'b1);
		push_sample(-95, 1'b1);
		push_sample(3, 1'b0);
		push_sample(VAL_MIN, 1'b1);
		push_sample(VAL_MAX, 1'b1);

		// hysteresis bound below the most negative value, undefined with zero severity
		c = '{hihi: VAL_MIN + 5, lolo: 0, high: 0, low: 0, hyst: VAL_MAX, sevr: 10'h003,
			mdel: VAL_MAX, adel: 0};
		write_cfg(c);
		push_sample(VAL_MIN + 5, 1'b1);
		push_sample(VAL_MIN, 1'b1);
		push_sample(7, 1'b0);
		push_sample(VAL_MAX, 1'b1);
		push_sample(VAL_MIN, 1'b1);
		push_sample(VAL_MIN, 1'b1);

		// most negative hysteresis, bound below the bottom of the range
		c = '{hihi: 0, lolo: VAL_MIN + 2, high: 0, low: 0, hyst: VAL_MIN, sevr: 10'h008,
			mdel: VAL_MIN, adel: VAL_MAX};
		write_cfg(c);
		push_sample(VAL_MIN, 1'b1);
		push_sample(VAL_MIN + 2, 1'b1);
		push_sample(VAL_MIN + 3, 1'b1);
		push_sample(0, 1'b1);

		for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
			off    = lah_pkg::val_t'($urandom_range(0, 2000));
			center = off - 1000;
			spread = lah_pkg::val_t'($urandom_range(1, 200));
			c.hihi = center + 2 * spread;
			c.high = center + spread;
			c.low  = center - spread;
			c.lolo = center - 2 * spread;
			if ($urandom_range(0, 6) == 0)
				c.hihi = {$urandom, $urandom};
			if ($urandom_range(0, 6) == 0)
				c.lolo = {$urandom, $urandom};
			if ($urandom_range(0, 6) == 0)
				c.high = {$urandom, $urandom};
			if ($urandom_range(0, 6) == 0)
				c.low = {$urandom, $urandom};
			pick = $urandom_range(0, 19);
			if (pick < 14)
				c.hyst = lah_pkg::val_t'($urandom_range(0, 30));
			else if (pick < 17)
				c.hyst = -lah_pkg::val_t'($urandom_range(1, 30));
			else if (pick == 17)
				c.hyst = VAL_MAX;
			else if (pick == 18)
				c.hyst = VAL_MIN;
			else
				c.hyst = {$urandom, $urandom};
			c.sevr = (ph == 0) ? 10'h3FF : (lah_pkg::SEV_W)'($urandom_range(0, 1023));
			c.mdel = pick_band();
			c.adel = pick_band();
			if (ph == RANDOM_PHASES - 1) begin
				c.hihi = VAL_MAX;
				c.high = VAL_MAX - 1;
				c.low  = VAL_MIN + 1;
				c.lolo = VAL_MIN;
				c.hyst = VAL_MAX;
			end
			write_cfg(c);
			tx_gap_max   = $urandom_range(0, 1) ? $urandom_range(1, 12) : 0;
			rx_stall_max = $urandom_range(0, 1) ? $urandom_range(1, 10) : 0;
			if (ph == 2) begin
				tx_gap_max  = 0;
				pressure_go = 1'b1;
			end
			walk = c.high;
			for (int i = 0; i < PHASE_ITEMS; i++) begin
				pick = $urandom_range(0, 99);
				if (pick < 12) begin
					case ($urandom_range(0, 3))
						0: walk = c.hihi;
						1: walk = c.lolo;
						2: walk = c.high;
						default: walk = c.low;
					endcase
					off  = lah_pkg::val_t'($urandom_range(0, 8));
					walk = walk + off - 4;
				end else if (pick < 22) begin
					walk = {$urandom, $urandom};
				end else if (pick < 27) begin
					case ($urandom_range(0, 3))
						0: walk = VAL_MIN;
						1: walk = VAL_MAX;
						2: walk = 0;
						default: walk = -1;
					endcase
				end else begin
					off  = lah_pkg::val_t'($urandom_range(0, 40));
					walk = walk + off - 20;
				end
				push_sample(walk, $urandom_range(0, 9) != 0);
			end
		end

		do
			@(negedge clk);
		while (samples_pending.size() != 0 || sample_ch.valid);
		drain = 0;
		while (alarm_expected.size() != 0 && drain < DRAIN_LIMIT) begin
			@(negedge clk);
			drain++;
		end
		repeat (4) @(posedge clk);
		if (alarm_expected.size() != 0)
			report_mismatch("missing results", 0, 64'(alarm_expected.size()));
		if (err_count == 0)
			$display("tb: done, clean");
		else
			$display("tb: done, errors");
		$finish;
	end

endmodule

>>> sim.f
src/lah_pkg.sv
src/lah_sample_if.sv
src/lah_result_if.sv
src/lah_regs.sv
src/limit_alarm_with_hysteresis_unit.sv
tb/tb.sv
